[hw/rtl/j1939fd_pkg.sv]
package j1939fd_pkg;

    // One bit per possible record of a frame, in output order.
    localparam int SlotCount = 24;
    typedef logic [SlotCount-1:0] slot_mask_t;
    typedef logic [4:0] slot_idx_t;
    typedef logic [4:0] kind_t;

    // Parameter group numbers that get field decoding.
    localparam logic [17:0] PGN_EEC1    = 18'd61444;
    localparam logic [17:0] PGN_ET1     = 18'd65262;
    localparam logic [17:0] PGN_CCVS    = 18'd65265;
    localparam logic [17:0] PGN_REQUEST = 18'd59904;
    localparam logic [17:0] PGN_DM1     = 18'd65226;

    localparam logic [17:0] PDU1_PGN_MASK = 18'h3FF00;
    localparam logic [7:0]  PDU2_PF_FIRST = 8'd240;
    localparam logic [7:0]  GLOBAL_ADDR   = 8'hFF;
    localparam logic [3:0]  MAX_LEN       = 4'd8;

    localparam logic [24:0] TORQUE_OFFSET = 25'd125;
    localparam logic [24:0] TEMP_OFFSET   = 25'd40;
    localparam logic [24:0] OIL_OFFSET    = 25'd8736;

    // Record kinds.
    localparam kind_t KIND_HEADER     = 5'd0;
    localparam kind_t KIND_EEC1_DEM   = 5'd1;
    localparam kind_t KIND_EEC1_ACT   = 5'd2;
    localparam kind_t KIND_EEC1_SPEED = 5'd3;
    localparam kind_t KIND_ET1_COOL   = 5'd4;
    localparam kind_t KIND_ET1_FUEL   = 5'd5;
    localparam kind_t KIND_ET1_OIL    = 5'd6;
    localparam kind_t KIND_CCVS_SPEED = 5'd7;
    localparam kind_t KIND_CCVS_CRUISE = 5'd8;
    localparam kind_t KIND_REQ_PGN    = 5'd9;
    localparam kind_t KIND_DM1_MIL    = 5'd10;
    localparam kind_t KIND_DM1_RSL    = 5'd11;
    localparam kind_t KIND_DM1_AWL    = 5'd12;
    localparam kind_t KIND_DM1_PL     = 5'd13;
    localparam kind_t KIND_DM1_FLASH  = 5'd14;
    localparam kind_t KIND_DM1_SPN    = 5'd15;
    localparam kind_t KIND_DM1_FMI    = 5'd16;
    localparam kind_t KIND_DM1_CM     = 5'd17;
    localparam kind_t KIND_DM1_OC     = 5'd18;
    localparam kind_t KIND_NOTE_FD    = 5'd19;
    localparam kind_t KIND_NOTE_SHORT = 5'd20;
    localparam kind_t KIND_NOTE_MISS  = 5'd21;
    localparam kind_t KIND_NOTE_DTC   = 5'd22;
    localparam kind_t KIND_OTHER      = 5'd23;

    // One decoded frame waiting for the record sequencer.
    typedef struct packed {
        logic        accepted;
        logic [2:0]  prio;
        logic [17:0] pgn;
        logic [7:0]  sa;
        logic [7:0]  da;
        logic        pdu1;
        logic        glob;
        logic [3:0]  len;
        logic [63:0] payload;
        slot_mask_t  mask;
    } frame_entry_t;

    // The FD note goes right after the header; all other kinds keep their order.
    function automatic slot_idx_t kind_to_slot(input kind_t kind);
        slot_idx_t slot;
        if (kind == KIND_HEADER) begin
            slot = 5'd0;
        end else if (kind == KIND_NOTE_FD) begin
            slot = 5'd1;
        end else if (kind < KIND_NOTE_FD) begin
            slot = kind + 5'd1;
        end else begin
            slot = kind;
        end
        return slot;
    endfunction

    function automatic kind_t slot_to_kind(input slot_idx_t slot);
        kind_t kind;
        if (slot == 5'd0) begin
            kind = KIND_HEADER;
        end else if (slot == 5'd1) begin
            kind = KIND_NOTE_FD;
        end else if (slot < 5'd20) begin
            kind = slot - 5'd1;
        end else begin
            kind = slot;
        end
        return kind;
    endfunction

endpackage

[hw/rtl/j1939fd_front.sv]
module j1939fd_front
    import j1939fd_pkg::*;
(
    input  logic [28:0]  frame_id,
    input  logic         extended_format,
    input  logic         error_frame,
    input  logic         remote_request,
    input  logic         flexible_data,
    input  logic [3:0]   payload_length,
    input  logic [63:0]  payload_bytes,
    output frame_entry_t entry
);

    logic [17:0] pgn18;
    logic [7:0]  pf;
    logic [7:0]  ps;
    logic [3:0]  len;
    logic [1:0]  dtc_rem;
    slot_mask_t  mask;

    assign pgn18   = frame_id[25:8];
    assign pf      = frame_id[23:16];
    assign ps      = frame_id[15:8];
    assign len     = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
    assign dtc_rem = len[1:0] - 2'd2;

    // Work out which records the frame will produce.
    always_comb begin
        entry = '0;
        mask  = '0;
        if (extended_format && !error_frame) begin
            entry.accepted = 1'b1;
            entry.prio     = frame_id[28:26];
            entry.sa       = frame_id[7:0];
            if (pf < PDU2_PF_FIRST) begin
                entry.pgn  = pgn18 & PDU1_PGN_MASK;
                entry.da   = ps;
                entry.pdu1 = 1'b1;
                entry.glob = (ps == GLOBAL_ADDR);
            end else begin
                entry.pgn  = pgn18;
            end
            mask[kind_to_slot(KIND_HEADER)]  = 1'b1;
            mask[kind_to_slot(KIND_NOTE_FD)] = flexible_data;
            if (!remote_request) begin
                priority if (entry.pgn == PGN_EEC1) begin
                    if (len < 4'd5) begin
                        mask[kind_to_slot(KIND_NOTE_SHORT)] = 1'b1;
                    end else begin
                        mask[kind_to_slot(KIND_EEC1_DEM)]   = 1'b1;
                        mask[kind_to_slot(KIND_EEC1_ACT)]   = 1'b1;
                        mask[kind_to_slot(KIND_EEC1_SPEED)] = 1'b1;
                    end
                end else if (entry.pgn == PGN_ET1) begin
                    if (len < 4'd2) begin
                        mask[kind_to_slot(KIND_NOTE_SHORT)] = 1'b1;
                    end else begin
                        mask[kind_to_slot(KIND_ET1_COOL)] = 1'b1;
                        mask[kind_to_slot(KIND_ET1_FUEL)] = 1'b1;
                        mask[kind_to_slot(KIND_ET1_OIL)]  = (len >= 4'd4);
                    end
                end else if (entry.pgn == PGN_CCVS) begin
                    mask[kind_to_slot(KIND_CCVS_SPEED)]  = (len >= 4'd2);
                    mask[kind_to_slot(KIND_CCVS_CRUISE)] = (len >= 4'd3);
                    mask[kind_to_slot(KIND_NOTE_MISS)]   = (len < 4'd2);
                end else if (entry.pgn == PGN_REQUEST) begin
                    mask[kind_to_slot(KIND_REQ_PGN)]   = (len >= 4'd3);
                    mask[kind_to_slot(KIND_NOTE_MISS)] = (len < 4'd3);
                end else if (entry.pgn == PGN_DM1) begin
                    if (len == 4'd0) begin
                        mask[kind_to_slot(KIND_NOTE_MISS)] = 1'b1;
                    end else begin
                        mask[kind_to_slot(KIND_DM1_MIL)]   = 1'b1;
                        mask[kind_to_slot(KIND_DM1_RSL)]   = 1'b1;
                        mask[kind_to_slot(KIND_DM1_AWL)]   = 1'b1;
                        mask[kind_to_slot(KIND_DM1_PL)]    = 1'b1;
                        mask[kind_to_slot(KIND_DM1_FLASH)] = (len >= 4'd2);
                        // Eight bytes hold at most one complete DTC block.
                        mask[kind_to_slot(KIND_DM1_SPN)]   = (len >= 4'd6);
                        mask[kind_to_slot(KIND_DM1_FMI)]   = (len >= 4'd6);
                        mask[kind_to_slot(KIND_DM1_CM)]    = (len >= 4'd6);
                        mask[kind_to_slot(KIND_DM1_OC)]    = (len >= 4'd6);
                        mask[kind_to_slot(KIND_NOTE_DTC)]  =
                            (len > 4'd2) && (dtc_rem != 2'd0);
                    end
                end else begin
                    mask[kind_to_slot(KIND_OTHER)] = 1'b1;
                end
            end
        end else begin
            // A rejected frame yields one all-zero record.
            mask[kind_to_slot(KIND_HEADER)] = 1'b1;
        end
        entry.len     = len;
        entry.payload = payload_bytes;
        entry.mask    = mask;
    end

endmodule

[hw/rtl/j1939fd_queue.sv]
module j1939fd_queue
    import j1939fd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  frame_entry_t in_entry,
    output logic         out_valid,
    input  logic         out_ready,
    output frame_entry_t out_entry
);

    frame_entry_t entries_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_entry = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

[hw/rtl/j1939fd_back.sv]
module j1939fd_back
    import j1939fd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  frame_entry_t       q_entry,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_accepted,
    output logic [2:0]         m_priority_res,
    output logic [17:0]        m_pgn,
    output logic [7:0]         m_src_addr,
    output logic [7:0]         m_dst_addr,
    output logic               m_is_addressed,
    output logic               m_to_global,
    output logic [4:0]         m_record_kind,
    output logic signed [24:0] m_record_value,
    output logic               m_last_record
);

    function automatic logic signed [24:0] value_of(input kind_t kind,
                                                    input logic [63:0] p,
                                                    input logic [3:0] len);
        logic [7:0]  b0, b1, b2, b3, b4, b5;
        logic [24:0] v;
        b0 = p[7:0];
        b1 = p[15:8];
        b2 = p[23:16];
        b3 = p[31:24];
        b4 = p[39:32];
        b5 = p[47:40];
        unique case (kind)
            KIND_EEC1_DEM:    v = {17'd0, b1} - TORQUE_OFFSET;
            KIND_EEC1_ACT:    v = {17'd0, b2} - TORQUE_OFFSET;
            KIND_EEC1_SPEED:  v = {9'd0, b4, b3};
            KIND_ET1_COOL:    v = {17'd0, b0} - TEMP_OFFSET;
            KIND_ET1_FUEL:    v = {17'd0, b1} - TEMP_OFFSET;
            KIND_ET1_OIL:     v = {9'd0, b3, b2} - OIL_OFFSET;
            KIND_CCVS_SPEED:  v = {9'd0, b1, b0};
            KIND_CCVS_CRUISE: v = {23'd0, b2[7:6]};
            KIND_REQ_PGN:     v = {1'b0, b2, b1, b0};
            KIND_DM1_MIL:     v = {23'd0, b0[7:6]};
            KIND_DM1_RSL:     v = {23'd0, b0[5:4]};
            KIND_DM1_AWL:     v = {23'd0, b0[3:2]};
            KIND_DM1_PL:      v = {23'd0, b0[1:0]};
            KIND_DM1_FLASH:   v = {17'd0, b1};
            KIND_DM1_SPN:     v = {6'd0, b4[7:5], b3, b2};
            KIND_DM1_FMI:     v = {20'd0, b4[4:0]};
            KIND_DM1_CM:      v = {24'd0, b5[7]};
            KIND_DM1_OC:      v = {18'd0, b5[6:0]};
            KIND_NOTE_SHORT,
            KIND_NOTE_MISS,
            KIND_NOTE_DTC,
            KIND_OTHER:       v = {21'd0, len};
            default:          v = '0;
        endcase
        return signed'(v);
    endfunction

    frame_entry_t cur_reg;
    slot_mask_t   mask_reg;
    logic         busy_reg;
    logic         out_valid_reg;
    slot_idx_t    sel_slot;
    slot_mask_t   rest_mask;
    kind_t        sel_kind;
    logic         advance, emit, last, take;

    // Lowest pending slot is the next record.
    always_comb begin
        sel_slot = '0;
        for (int i = SlotCount - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel_slot = slot_idx_t'(i);
            end
        end
    end

    assign rest_mask = mask_reg & ~(slot_mask_t'(1) << sel_slot);
    assign sel_kind  = slot_to_kind(sel_slot);
    assign last      = (rest_mask == '0);
    assign advance   = !out_valid_reg || m_ready;
    assign emit      = busy_reg && advance;
    assign q_ready   = !busy_reg || (emit && last);
    assign take      = q_valid && q_ready;
    assign m_valid   = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= busy_reg;
            end
            if (take) begin
                busy_reg <= 1'b1;
            end else if (emit && last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cur_reg  <= q_entry;
            mask_reg <= q_entry.mask;
        end else if (emit) begin
            mask_reg <= rest_mask;
        end
        if (emit) begin
            m_frame_accepted <= cur_reg.accepted;
            m_priority_res   <= cur_reg.prio;
            m_pgn            <= cur_reg.pgn;
            m_src_addr       <= cur_reg.sa;
            m_dst_addr       <= cur_reg.da;
            m_is_addressed   <= cur_reg.pdu1;
            m_to_global      <= cur_reg.glob;
            m_record_kind    <= sel_kind;
            m_record_value   <= value_of(sel_kind, cur_reg.payload, cur_reg.len);
            m_last_record    <= last;
        end
    end

endmodule

[hw/rtl/j1939_frame_decoder_core.sv]
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | one CAN frame: identifier, flags, length, bytes
// m_       | out       | m_valid / m_ready  | one record: header fields, kind, value, last flag
//
// Each frame yields one to twelve records, one record per clock cycle while m_ready does
// not stall the output.
// The front end classifies a frame in the cycle it is accepted and pushes it into a
// two-entry queue; the sequencer pulls the next frame while emitting the last record.
// Reset (aresetn, synchronous, active low) empties the queue and the output register.
// A stalled m_ready holds the output record; s_ready drops only when the queue is full.
module j1939_frame_decoder_core
    import j1939fd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [28:0]        s_frame_id,
    input  logic               s_extended_format,
    input  logic               s_error_frame,
    input  logic               s_remote_request,
    input  logic               s_flexible_data,
    input  logic [3:0]         s_payload_length,
    input  logic [63:0]        s_payload_bytes,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_accepted,
    output logic [2:0]         m_priority_res,
    output logic [17:0]        m_pgn,
    output logic [7:0]         m_src_addr,
    output logic [7:0]         m_dst_addr,
    output logic               m_is_addressed,
    output logic               m_to_global,
    output logic [4:0]         m_record_kind,
    output logic signed [24:0] m_record_value,
    output logic               m_last_record
);

    // The front end turns the frame into header fields plus a mask with one bit per
    // record that the frame will produce, kept in output order.
    frame_entry_t front_entry;
    frame_entry_t q_entry;
    logic         q_valid;
    logic         q_ready;

    j1939fd_front u_front (
        .frame_id        (s_frame_id),
        .extended_format (s_extended_format),
        .error_frame     (s_error_frame),
        .remote_request  (s_remote_request),
        .flexible_data   (s_flexible_data),
        .payload_length  (s_payload_length),
        .payload_bytes   (s_payload_bytes),
        .entry           (front_entry)
    );

    // The queue decouples frame acceptance from record emission, so a new transaction
    // can be taken while records of an earlier frame are still going out.
    j1939fd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_entry  (front_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    // The sequencer walks the mask lowest bit first and computes each record's value
    // from the stored payload into the output register.
    j1939fd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_entry          (q_entry),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_accepted (m_frame_accepted),
        .m_priority_res   (m_priority_res),
        .m_pgn            (m_pgn),
        .m_src_addr       (m_src_addr),
        .m_dst_addr       (m_dst_addr),
        .m_is_addressed   (m_is_addressed),
        .m_to_global      (m_to_global),
        .m_record_kind    (m_record_kind),
        .m_record_value   (m_record_value),
        .m_last_record    (m_last_record)
    );

endmodule

[bench/tb_j1939_frame_decoder_core.sv]
module tb_j1939_frame_decoder_core;
    import j1939fd_pkg::*;

    // The longest stretch without any accepted transaction on either channel
    // before the run is declared hung. The deliberate receiver hold-off below
    // lasts HOLD_CYCLES, so the limit sits well above it.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    // Cycles to keep watching the result channel once nothing is expected.
    localparam int DRAIN_CYCLES   = 40;

    // One CAN frame as offered on the input channel.
    typedef struct {
        logic [28:0] id;
        logic        ext;
        logic        err;
        logic        rtr;
        logic        fd;
        logic [3:0]  len;
        logic [63:0] bytes;
    } can_frame_t;

    // One decoded record as it should appear on the result channel.
    typedef struct {
        logic               accepted;
        logic [2:0]         prio;
        logic [17:0]        pgn;
        logic [7:0]         sa;
        logic [7:0]         da;
        logic               pdu1;
        logic               glob;
        kind_t              kind;
        logic signed [24:0] value;
        logic               last_rec;
    } decoded_record_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [28:0]        s_frame_id = '0;
    logic               s_extended_format = 1'b0;
    logic               s_error_frame = 1'b0;
    logic               s_remote_request = 1'b0;
    logic               s_flexible_data = 1'b0;
    logic [3:0]         s_payload_length = '0;
    logic [63:0]        s_payload_bytes = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_frame_accepted;
    logic [2:0]         m_priority_res;
    logic [17:0]        m_pgn;
    logic [7:0]         m_src_addr;
    logic [7:0]         m_dst_addr;
    logic               m_is_addressed;
    logic               m_to_global;
    logic [4:0]         m_record_kind;
    logic signed [24:0] m_record_value;
    logic               m_last_record;

    // Records predicted for accepted frames, oldest first.
    decoded_record_t pending_records[$];
    // Scratch space for the records of the frame being decoded.
    decoded_record_t frame_run[$];
    decoded_record_t cur_header;

    int mismatch_count = 0;
    int quiet_cycles = 0;
    // Idle and stall probabilities in percent, set per test phase.
    int sender_idle_pct = 0;
    int stall_pct = 0;
    // Remaining cycles of a forced receiver hold-off.
    int hold_left = 0;

    j1939_frame_decoder_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_frame_id        (s_frame_id),
        .s_extended_format (s_extended_format),
        .s_error_frame     (s_error_frame),
        .s_remote_request  (s_remote_request),
        .s_flexible_data   (s_flexible_data),
        .s_payload_length  (s_payload_length),
        .s_payload_bytes   (s_payload_bytes),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_accepted  (m_frame_accepted),
        .m_priority_res    (m_priority_res),
        .m_pgn             (m_pgn),
        .m_src_addr        (m_src_addr),
        .m_dst_addr        (m_dst_addr),
        .m_is_addressed    (m_is_addressed),
        .m_to_global       (m_to_global),
        .m_record_kind     (m_record_kind),
        .m_record_value    (m_record_value),
        .m_last_record     (m_last_record)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Appends one record carrying the current header fields.
    function automatic void add_record(kind_t kind, int val);
        decoded_record_t r;
        r          = cur_header;
        r.kind     = kind;
        r.value    = val[24:0];
        r.last_rec = 1'b0;
        frame_run.insert(frame_run.size(), r);
    endfunction

    // Works out every record that one accepted frame must produce and queues
    // them behind the records still outstanding from earlier frames.
    task automatic predict_frame_records(input can_frame_t f);
        int              len;
        int              b[8];
        int              rem;
        logic [17:0]     pgn18;
        logic [7:0]      pf;
        logic [7:0]      ps;
        decoded_record_t tail;

        for (int k = 0; k < 8; k++) begin
            b[k] = int'(f.bytes[8*k +: 8]);
        end
        // Lengths above eight are treated as eight.
        len = (f.len > MAX_LEN) ? int'(MAX_LEN) : int'(f.len);

        // A standard-format or error frame gives a single all-zero record
        // that only carries the last flag.
        if (!f.ext || f.err) begin
            tail          = '{default: '0};
            tail.last_rec = 1'b1;
            pending_records.insert(pending_records.size(), tail);
            return;
        end

        pgn18 = f.id[25:8];
        pf    = f.id[23:16];
        ps    = f.id[15:8];
        cur_header          = '{default: '0};
        cur_header.accepted = 1'b1;
        cur_header.prio     = f.id[28:26];
        cur_header.sa       = f.id[7:0];
        if (pf < PDU2_PF_FIRST) begin
            // PDU1: the PS byte is the destination and is cleared from the PGN.
            cur_header.pgn  = pgn18 & PDU1_PGN_MASK;
            cur_header.da   = ps;
            cur_header.pdu1 = 1'b1;
            cur_header.glob = (ps == GLOBAL_ADDR);
        end else begin
            cur_header.pgn = pgn18;
        end

        frame_run.delete();
        add_record(KIND_HEADER, 0);
        if (f.fd) begin
            add_record(KIND_NOTE_FD, 0);
        end

        // A remote frame ends after the header and the optional FD note.
        if (!f.rtr) begin
            case (cur_header.pgn)
                PGN_EEC1: begin
                    if (len < 5) begin
                        add_record(KIND_NOTE_SHORT, len);
                    end else begin
                        add_record(KIND_EEC1_DEM, b[1] - int'(TORQUE_OFFSET));
                        add_record(KIND_EEC1_ACT, b[2] - int'(TORQUE_OFFSET));
                        add_record(KIND_EEC1_SPEED, b[3] | (b[4] << 8));
                    end
                end
                PGN_ET1: begin
                    if (len < 2) begin
                        add_record(KIND_NOTE_SHORT, len);
                    end else begin
                        add_record(KIND_ET1_COOL, b[0] - int'(TEMP_OFFSET));
                        add_record(KIND_ET1_FUEL, b[1] - int'(TEMP_OFFSET));
                        if (len >= 4) begin
                            add_record(KIND_ET1_OIL, (b[2] | (b[3] << 8)) - int'(OIL_OFFSET));
                        end
                    end
                end
                PGN_CCVS: begin
                    if (len >= 2) begin
                        add_record(KIND_CCVS_SPEED, b[0] | (b[1] << 8));
                    end
                    if (len >= 3) begin
                        add_record(KIND_CCVS_CRUISE, (b[2] >> 6) & 3);
                    end
                    if (len < 2) begin
                        add_record(KIND_NOTE_MISS, len);
                    end
                end
                PGN_REQUEST: begin
                    if (len >= 3) begin
                        add_record(KIND_REQ_PGN, b[0] | (b[1] << 8) | (b[2] << 16));
                    end else begin
                        add_record(KIND_NOTE_MISS, len);
                    end
                end
                PGN_DM1: begin
                    if (len < 1) begin
                        add_record(KIND_NOTE_MISS, len);
                    end else begin
                        add_record(KIND_DM1_MIL, (b[0] >> 6) & 3);
                        add_record(KIND_DM1_RSL, (b[0] >> 4) & 3);
                        add_record(KIND_DM1_AWL, (b[0] >> 2) & 3);
                        add_record(KIND_DM1_PL, b[0] & 3);
                        if (len >= 2) begin
                            add_record(KIND_DM1_FLASH, b[1]);
                        end
                        if (len > 2) begin
                            rem = len - 2;
                            // Each whole four-byte block after the flash byte is one DTC.
                            for (int off = 2; off + 4 <= len; off += 4) begin
                                add_record(KIND_DM1_SPN, b[off] | (b[off+1] << 8) |
                                           (((b[off+2] >> 5) & 7) << 16));
                                add_record(KIND_DM1_FMI, b[off+2] & 'h1F);
                                add_record(KIND_DM1_CM, (b[off+3] >> 7) & 1);
                                add_record(KIND_DM1_OC, b[off+3] & 'h7F);
                            end
                            if ((rem % 4) != 0) begin
                                add_record(KIND_NOTE_DTC, len);
                            end
                        end
                    end
                end
                default: begin
                    add_record(KIND_OTHER, len);
                end
            endcase
        end

        frame_run[frame_run.size() - 1].last_rec = 1'b1;
        foreach (frame_run[i]) begin
            pending_records.insert(pending_records.size(), frame_run[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Every record transaction is compared with the oldest prediction.
    always @(posedge aclk) begin
        decoded_record_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                report_mismatch($sformatf("record of kind %0d with none expected",
                                          m_record_kind));
            end else begin
                want = pending_records.pop_front();
                check_field("frame_accepted", longint'(m_frame_accepted),
                            longint'(want.accepted));
                check_field("priority_res", longint'(m_priority_res), longint'(want.prio));
                check_field("pgn", longint'(m_pgn), longint'(want.pgn));
                check_field("src_addr", longint'(m_src_addr), longint'(want.sa));
                check_field("dst_addr", longint'(m_dst_addr), longint'(want.da));
                check_field("is_addressed", longint'(m_is_addressed), longint'(want.pdu1));
                check_field("to_global", longint'(m_to_global), longint'(want.glob));
                check_field("record_kind", longint'(m_record_kind), longint'(want.kind));
                check_field("record_value", longint'(m_record_value), longint'(want.value));
                check_field("last_record", longint'(m_last_record), longint'(want.last_rec));
            end
        end
    end

    // Hang detection: any accepted transaction on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("j1939_frame_decoder_core regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------

    // The receiver either sits out a forced hold-off, counted down here, or
    // stalls at random with the probability of the current phase.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one frame, optionally after an idle gap, and holds it until the
    // block takes it. The prediction is made at the accepting edge.
    task automatic send_frame(input can_frame_t f);
        int gap;
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct && gap < 60) begin
            gap++;
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_frame_id        <= f.id;
        s_extended_format <= f.ext;
        s_error_frame     <= f.err;
        s_remote_request  <= f.rtr;
        s_flexible_data   <= f.fd;
        s_payload_length  <= f.len;
        s_payload_bytes   <= f.bytes;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_frame_records(f);
    endtask

    // Drops valid, then waits until every predicted record has arrived and
    // watches the result channel a little longer for stray records.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_records.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic can_frame_t mk_frame(logic [28:0] id, logic ext, logic err, logic rtr,
                                            logic fd, logic [3:0] len, logic [63:0] bytes);
        can_frame_t f;
        f.id    = id;
        f.ext   = ext;
        f.err   = err;
        f.rtr   = rtr;
        f.fd    = fd;
        f.len   = len;
        f.bytes = bytes;
        return f;
    endfunction

    // Builds an identifier from priority, the 18 PGN bits and the source.
    function automatic logic [28:0] pgn_id(logic [2:0] prio, logic [17:0] pgn, logic [7:0] sa);
        return {prio, pgn, sa};
    endfunction

    // Most random frames are well formed and aimed at a decoded PGN so the
    // field decoders get exercised; the rest is unconstrained noise.
    function automatic can_frame_t make_random_frame();
        can_frame_t  f;
        logic [17:0] pgn;
        logic [7:0]  dest;
        int          sel;
        f.bytes = {$urandom(), $urandom()};
        if ($urandom_range(99) < 12) begin
            f.id  = 29'($urandom());
            f.ext = 1'($urandom_range(1));
            f.err = 1'($urandom_range(1));
            f.rtr = 1'($urandom_range(1));
            f.fd  = 1'($urandom_range(1));
            f.len = 4'($urandom_range(15));
            return f;
        end
        sel  = $urandom_range(5);
        dest = 8'($urandom_range(255));
        case (sel)
            0:       pgn = PGN_EEC1;
            1:       pgn = PGN_ET1;
            2:       pgn = PGN_CCVS;
            3:       pgn = PGN_REQUEST | {10'd0, dest};
            4:       pgn = PGN_DM1;
            default: pgn = 18'($urandom_range(18'h3FFFF));
        endcase
        f.id  = pgn_id(3'($urandom_range(7)), pgn, 8'($urandom_range(255)));
        f.ext = 1'b1;
        f.err = ($urandom_range(19) == 0);
        f.rtr = ($urandom_range(14) == 0);
        f.fd  = ($urandom_range(3) == 0);
        f.len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked frames: rejection, each decoded PGN at its length
    // boundaries, remote frames, length saturation and identifier extremes.
    task automatic test_directed_frames();
        sender_idle_pct = 0;
        stall_pct       = 0;
        // Rejected: standard format, error frame, and both at once.
        send_frame(mk_frame(pgn_id(3, PGN_EEC1, 8'h00), 0, 0, 0, 0, 8, '1));
        send_frame(mk_frame(pgn_id(3, PGN_EEC1, 8'h00), 1, 1, 0, 0, 8, '1));
        send_frame(mk_frame(pgn_id(3, PGN_EEC1, 8'h00), 0, 1, 1, 1, 8, '1));
        // EEC1 with every byte at its extremes, then one byte too short.
        send_frame(mk_frame(pgn_id(7, PGN_EEC1, 8'hFF), 1, 0, 0, 0, 8, '1));
        send_frame(mk_frame(pgn_id(0, PGN_EEC1, 8'h00), 1, 0, 0, 0, 8, '0));
        send_frame(mk_frame(pgn_id(3, PGN_EEC1, 8'h00), 1, 0, 0, 0, 4, 64'h0000_00FF_7D7D_0000));
        // ET1: too short, without oil temperature, oil at both ends.
        send_frame(mk_frame(pgn_id(6, PGN_ET1, 8'h00), 1, 0, 0, 0, 1, 64'h28));
        send_frame(mk_frame(pgn_id(6, PGN_ET1, 8'h00), 1, 0, 0, 0, 2, 64'hFF00));
        send_frame(mk_frame(pgn_id(6, PGN_ET1, 8'h00), 1, 0, 0, 0, 4, 64'h0000_0000));
        send_frame(mk_frame(pgn_id(6, PGN_ET1, 8'h00), 1, 0, 0, 0, 4, 64'hFFFF_FFFF));
        // CCVS: no speed bytes, speed only, speed and cruise.
        send_frame(mk_frame(pgn_id(6, PGN_CCVS, 8'h11), 1, 0, 0, 0, 1, 64'hFF));
        send_frame(mk_frame(pgn_id(6, PGN_CCVS, 8'h11), 1, 0, 0, 0, 2, 64'hFFFF));
        send_frame(mk_frame(pgn_id(6, PGN_CCVS, 8'h11), 1, 0, 0, 0, 3, 64'hC0_FFFF));
        // Request: short to the global address, then a full one to a node.
        send_frame(mk_frame(pgn_id(6, PGN_REQUEST | 18'hFF, 8'h21), 1, 0, 0, 0, 2,
                            64'hFFFF));
        send_frame(mk_frame(pgn_id(6, PGN_REQUEST | 18'h17, 8'h21), 1, 0, 0, 0, 3,
                            64'hFF_FFFF));
        // DM1: empty, lamps only, lamps and flash, one whole DTC, a DTC plus a
        // ragged tail with the FD note (the longest run), and a ragged area alone.
        send_frame(mk_frame(pgn_id(6, PGN_DM1, 8'h00), 1, 0, 0, 0, 0, '1));
        send_frame(mk_frame(pgn_id(6, PGN_DM1, 8'h00), 1, 0, 0, 0, 1, 64'hE4));
        send_frame(mk_frame(pgn_id(6, PGN_DM1, 8'h00), 1, 0, 0, 0, 2, 64'hFF1B));
        send_frame(mk_frame(pgn_id(6, PGN_DM1, 8'h00), 1, 0, 0, 0, 6, 64'hFFFF_FFFF_FFFF));
        send_frame(mk_frame(pgn_id(6, PGN_DM1, 8'h00), 1, 0, 0, 1, 8, 64'h0102_807F_E0FF_55AA));
        send_frame(mk_frame(pgn_id(6, PGN_DM1, 8'h00), 1, 0, 0, 0, 3, '1));
        // Remote frames stop after the header, with and without the FD note.
        send_frame(mk_frame(pgn_id(3, PGN_EEC1, 8'h00), 1, 0, 1, 1, 8, '1));
        send_frame(mk_frame(pgn_id(3, PGN_DM1, 8'h00), 1, 0, 1, 0, 8, '1));
        // Undecoded PGN with every identifier bit set and a saturating length.
        send_frame(mk_frame(29'h1FFF_FFFF, 1, 0, 0, 0, 15, '1));
        // All-zero identifier: PDU1 with PGN 0 and destination 0.
        send_frame(mk_frame(29'h0, 1, 0, 0, 1, 0, '0));
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall);
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        repeat (count) begin
            send_frame(make_random_frame());
        end
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering frames, so the frame queue fills and s_ready has to drop.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_left       = HOLD_CYCLES;
        repeat (16) begin
            send_frame(make_random_frame());
        end
        wait_for_drain();
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_frames();
        test_random_traffic(70, 0, 0);
        test_random_traffic(70, 79, 0);
        test_random_traffic(70, 0, 79);
        test_random_traffic(70, 16, 16);
        test_backpressure();

        if (pending_records.size() != 0) begin
            report_mismatch($sformatf("%0d records never arrived", pending_records.size()));
        end
        if (mismatch_count == 0) begin
            $display("j1939_frame_decoder_core regression: pass");
        end else begin
            $display("j1939_frame_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
